// ===== rtl/pid_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_pkg: shared definitions for the pitch index decoder
// Field widths, fixed-point constants of the pitch law, the 2^x polynomial
// coefficients and the harmonic count limits.
// ----------------------------------------------------------------------------
package pid_pkg;

  localparam int INDEX_BITS_DEFAULT = 7;

  // Output field widths.
  localparam int PITCH_W = 15;
  localparam int HARM_W  = 6;

  // Serial datapath widths.
  localparam int Q_W     = 14;  // quotient of the log-pitch division
  localparam int MPLR_W  = 14;  // multiplier shift register, radix-4 digits
  localparam int MCAND_W = 15;
  localparam int ACC_W   = 28;
  localparam int MAG_W   = 15;
  localparam int FRAC_W  = 16;
  localparam int CNT_W   = 4;
  localparam int EXP_W   = 5;
  localparam int RAW_W   = 7;   // harmonic count before clamping

  // Step counts of the serial passes.
  localparam int POLY_DIGITS = 7;
  localparam int CHK_DIGITS  = 4;
  localparam int L_BITS      = 6;
  localparam int N_BITS      = 7;

  // Log-pitch law.
  localparam int PITCH_STEP = 'h2A52;
  localparam int PITCH_DIV  = 'h3C;
  localparam logic [MAG_W-1:0] PITCH_OFFSET = 15'h44FD;

  // 2^x evaluation.
  localparam logic [MAG_W-1:0]   ONE_Q12   = 15'h1000;
  localparam logic [ACC_W-1:0]   ROUND_Q12 = 28'h0000FFF;
  localparam logic [MCAND_W-1:0] POLY_LEAD = 15'h013B;
  localparam logic [EXP_W-1:0]   EXP_BIAS  = 5'd4;
  localparam logic [FRAC_W-1:0]  FRAC_FLIP = 16'h8000;

  // Fundamental limits (Q19).
  localparam logic [PITCH_W-1:0] PITCH_MIN = 15'h1079;
  localparam logic [PITCH_W-1:0] PITCH_MAX = 15'h6BCA;

  // Harmonic count.
  localparam int HARM_NUM = 'h3B39C;
  localparam int NYQ_NUM  = 'h80000;
  localparam logic [ACC_W-1:0]  NYQ_LIMIT = 28'h007FFFF;
  localparam logic [HARM_W-1:0] HARM_MIN  = 6'd9;
  localparam logic [HARM_W-1:0] HARM_MAX  = 6'h38;

  // Constant added after each Horner product, by step.
  function automatic logic [FRAC_W-1:0] poly_coef(input logic [1:0] step);
    logic [FRAC_W-1:0] c;
    case (step)
      2'd0:    c = 16'h071B;
      2'd1:    c = 16'h1EC0;
      2'd2:    c = 16'h58B9;
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic logic [HARM_W-1:0] harm_clamp(input logic [RAW_W-1:0] l);
    logic [HARM_W-1:0] r;
    if (l >= RAW_W'(HARM_MAX)) begin
      r = HARM_MAX;
    end else if (l < RAW_W'(HARM_MIN)) begin
      r = HARM_MIN;
    end else begin
      r = l[HARM_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/pitch_index_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pitch_index_decode: pitch quantizer index to fundamental and harmonic count
// Digit-serial decoder: one shared radix-4 multiplier and one shared
// restoring divider, driven by a one-hot sequencer.
// ----------------------------------------------------------------------------
// Usage
//   Request channel: req_valid / req_stall with pitch_index. A word is taken
//   when req_valid is high and req_stall is low. req_stall is high while an
//   index is being decoded, so one index is in work at a time.
//   Response channel: rsp_valid / rsp_stall with pitch_q19 and
//   harmonic_total, held in an output register. The next index is accepted
//   while an earlier result still waits there.
//   An index goes through the serial passes in order: the index multiply,
//   a 14-bit quotient, the range-reduction steps, four 7-digit Horner
//   products and up to two short divisions for the harmonic count.
//   If the receiver stalls, the finished result stays in the sequencer until
//   the output register frees up; its word in the output register holds.
//   Reset (rst, synchronous) returns the sequencer to idle and drops rsp_valid.
// ----------------------------------------------------------------------------
module pitch_index_decode #(
  parameter int INDEX_BITS = pid_pkg::INDEX_BITS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_stall,
  input  logic [INDEX_BITS-1:0]        pitch_index,
  output logic                         rsp_valid,
  input  logic                         rsp_stall,
  output logic [pid_pkg::PITCH_W-1:0]  pitch_q19,
  output logic [pid_pkg::HARM_W-1:0]   harmonic_total
);

  localparam int DIV_W      = INDEX_BITS + 15;
  localparam int NUM_DIGITS = (INDEX_BITS + 2) / 2;
  localparam int NUM_MPLR_W = 2 * NUM_DIGITS;
  // Divisor of the log-pitch division, aligned to the top quotient bit.
  localparam logic [DIV_W-1:0] Q_DSR =
    DIV_W'(2 * pid_pkg::PITCH_DIV) << (INDEX_BITS - 6 + pid_pkg::Q_W - 1);

  typedef enum logic [9:0] {
    S_IDLE    = 10'b0000000001,
    S_MUL_NUM = 10'b0000000010,
    S_DIV_Q   = 10'b0000000100,
    S_REDUCE  = 10'b0000001000,
    S_POLY    = 10'b0000010000,
    S_SCALE   = 10'b0000100000,
    S_DIV_L   = 10'b0001000000,
    S_MUL_CHK = 10'b0010000000,
    S_DIV_N   = 10'b0100000000,
    S_DONE    = 10'b1000000000
  } state_t;

  state_t                          state;
  logic [pid_pkg::CNT_W-1:0]       cnt;
  logic [pid_pkg::MPLR_W-1:0]      mplr;
  logic [pid_pkg::MCAND_W-1:0]     mcand;
  logic [pid_pkg::ACC_W-1:0]       acc;
  logic [DIV_W-1:0]                rem;
  logic [DIV_W-1:0]                dsr;
  logic [pid_pkg::Q_W-1:0]         quo;
  logic [pid_pkg::MAG_W-1:0]       mag;
  logic [2:0]                      n;
  logic [1:0]                      pstep;
  logic [pid_pkg::FRAC_W-1:0]      frac;
  logic [pid_pkg::PITCH_W-1:0]     f0;
  logic [pid_pkg::RAW_W-1:0]       lraw;

  logic [pid_pkg::MCAND_W+1:0]     pp;
  logic [pid_pkg::ACC_W-1:0]       acc_next;
  logic [pid_pkg::ACC_W-1:0]       rounded;
  logic [pid_pkg::ACC_W-1:0]       neg_prod;
  logic [pid_pkg::FRAC_W-1:0]      poly_t;
  logic                            div_ge;
  logic [pid_pkg::Q_W-1:0]         quo_next;
  logic [pid_pkg::EXP_W-1:0]       shamt;
  logic signed [pid_pkg::FRAC_W-1:0] scaled;
  logic [pid_pkg::PITCH_W-1:0]     f0_next;
  logic [pid_pkg::RAW_W-1:0]       nyq_l;
  logic                            last;
  logic                            rsp_free;

  assign req_stall = (state != S_IDLE);
  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign last      = (cnt == pid_pkg::CNT_W'(1));

  // Radix-4 multiply step, most significant digit first.
  always_comb begin
    case (mplr[pid_pkg::MPLR_W-1 -: 2])
      2'd0:    pp = '0;
      2'd1:    pp = (pid_pkg::MCAND_W+2)'(mcand);
      2'd2:    pp = (pid_pkg::MCAND_W+2)'({mcand, 1'b0});
      2'd3:    pp = (pid_pkg::MCAND_W+2)'(mcand) + (pid_pkg::MCAND_W+2)'({mcand, 1'b0});
      default: pp = '0;
    endcase
    acc_next = {acc[pid_pkg::ACC_W-3:0], 2'b00} + pid_pkg::ACC_W'(pp);
  end

  // The Horner argument is negative, so each product is carried as a
  // magnitude: floor(-p / 4096) is minus the rounded-up quotient.
  assign rounded  = acc_next + pid_pkg::ROUND_Q12;
  assign poly_t   = pid_pkg::poly_coef(pstep) - rounded[pid_pkg::ACC_W-1:12];
  assign neg_prod = -acc_next;

  assign div_ge   = (rem >= dsr);
  assign quo_next = {quo[pid_pkg::Q_W-2:0], div_ge};
  assign nyq_l    = (quo_next[pid_pkg::N_BITS-1:0] - pid_pkg::RAW_W'(1)) >> 1;

  // The exponent counts up from minus four; the shift takes it modulo 32.
  assign shamt  = pid_pkg::EXP_W'(n) - pid_pkg::EXP_BIAS;
  assign scaled = $signed(frac) >>> shamt;

  always_comb begin
    if (scaled < $signed(pid_pkg::FRAC_W'(pid_pkg::PITCH_MIN))) begin
      f0_next = pid_pkg::PITCH_MIN;
    end else if (scaled > $signed(pid_pkg::FRAC_W'(pid_pkg::PITCH_MAX))) begin
      f0_next = pid_pkg::PITCH_MAX;
    end else begin
      f0_next = scaled[pid_pkg::PITCH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      // In S_DONE the output register is reloaded whenever it frees up.
      if (rsp_valid && !rsp_stall && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            mplr  <= {NUM_MPLR_W'({pitch_index, 1'b1}),
                      (pid_pkg::MPLR_W - NUM_MPLR_W)'(0)};
            mcand <= pid_pkg::MCAND_W'(pid_pkg::PITCH_STEP);
            acc   <= '0;
            cnt   <= pid_pkg::CNT_W'(NUM_DIGITS);
            state <= S_MUL_NUM;
          end
        end
        S_MUL_NUM: begin
          acc  <= acc_next;
          mplr <= mplr << 2;
          if (last) begin
            rem   <= acc_next[DIV_W-1:0];
            dsr   <= Q_DSR;
            quo   <= '0;
            cnt   <= pid_pkg::CNT_W'(pid_pkg::Q_W);
            state <= S_DIV_Q;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        S_DIV_Q: begin
          if (div_ge) begin
            rem <= rem - dsr;
          end
          dsr <= dsr >> 1;
          quo <= quo_next;
          cnt <= cnt - 1'b1;
          if (last) begin
            mag   <= pid_pkg::MAG_W'(quo_next) + pid_pkg::PITCH_OFFSET;
            n     <= '0;
            state <= S_REDUCE;
          end
        end
        S_REDUCE: begin
          // Fold the argument into [-1, 0) in Q12, one unit per cycle.
          if (mag > pid_pkg::ONE_Q12) begin
            mag <= mag - pid_pkg::ONE_Q12;
            n   <= n + 1'b1;
          end else begin
            mplr  <= {1'b0, mag[12:0]};
            mcand <= pid_pkg::POLY_LEAD;
            acc   <= '0;
            cnt   <= pid_pkg::CNT_W'(pid_pkg::POLY_DIGITS);
            pstep <= '0;
            state <= S_POLY;
          end
        end
        S_POLY: begin
          if (last) begin
            if (pstep == 2'd3) begin
              frac  <= neg_prod[pid_pkg::ACC_W-1:12] ^ pid_pkg::FRAC_FLIP;
              state <= S_SCALE;
            end else begin
              mplr  <= {1'b0, mag[12:0]};
              mcand <= poly_t[pid_pkg::MCAND_W-1:0];
              acc   <= '0;
              cnt   <= pid_pkg::CNT_W'(pid_pkg::POLY_DIGITS);
              pstep <= pstep + 1'b1;
            end
          end else begin
            acc  <= acc_next;
            mplr <= mplr << 2;
            cnt  <= cnt - 1'b1;
          end
        end
        S_SCALE: begin
          f0    <= f0_next;
          rem   <= DIV_W'(pid_pkg::HARM_NUM);
          dsr   <= DIV_W'(f0_next) << (pid_pkg::L_BITS - 1);
          quo   <= '0;
          cnt   <= pid_pkg::CNT_W'(pid_pkg::L_BITS);
          state <= S_DIV_L;
        end
        S_DIV_L: begin
          if (div_ge) begin
            rem <= rem - dsr;
          end
          dsr <= dsr >> 1;
          quo <= quo_next;
          if (last) begin
            lraw  <= {1'b0, quo_next[pid_pkg::L_BITS-1:0]};
            mplr  <= {1'b0, quo_next[pid_pkg::L_BITS-1:0], 1'b1, 6'b000000};
            mcand <= f0;
            acc   <= '0;
            cnt   <= pid_pkg::CNT_W'(pid_pkg::CHK_DIGITS);
            state <= S_MUL_CHK;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        S_MUL_CHK: begin
          // Nyquist guard: the top harmonic must stay below half the rate.
          acc  <= acc_next;
          mplr <= mplr << 2;
          if (last) begin
            if (acc_next > pid_pkg::NYQ_LIMIT) begin
              rem   <= DIV_W'(pid_pkg::NYQ_NUM);
              dsr   <= DIV_W'(f0) << (pid_pkg::N_BITS - 1);
              quo   <= '0;
              cnt   <= pid_pkg::CNT_W'(pid_pkg::N_BITS);
              state <= S_DIV_N;
            end else begin
              state <= S_DONE;
            end
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        S_DIV_N: begin
          if (div_ge) begin
            rem <= rem - dsr;
          end
          dsr <= dsr >> 1;
          quo <= quo_next;
          cnt <= cnt - 1'b1;
          if (last) begin
            lraw  <= nyq_l;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (rsp_free) begin
            pitch_q19      <= f0;
            harmonic_total <= pid_pkg::harm_clamp(lraw);
            rsp_valid      <= 1'b1;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/pid_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_checker: port-level checks for the pitch index decoder
// Watches the two channels and the result ranges; bound to the decoder module.
// ----------------------------------------------------------------------------
module pid_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_valid,
  input logic                        req_stall,
  input logic                        rsp_valid,
  input logic                        rsp_stall,
  input logic [pid_pkg::PITCH_W-1:0] pitch_q19,
  input logic [pid_pkg::HARM_W-1:0]  harmonic_total
);

  // After reset the decoder is idle and shows no result.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !rsp_valid && !req_stall)
    else $error("decoder not idle after reset");

  // Only one index is in work: taking a word closes the request side.
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken while an index is in work");

  // A stalled result word holds.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(pitch_q19) &&
      $stable(harmonic_total))
    else $error("stalled result word changed");

  // Every result lies within the clamp limits.
  a_rsp_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> pitch_q19 >= pid_pkg::PITCH_MIN &&
      pitch_q19 <= pid_pkg::PITCH_MAX &&
      harmonic_total >= pid_pkg::HARM_MIN &&
      harmonic_total <= pid_pkg::HARM_MAX)
    else $error("result outside its clamp range");

endmodule

bind pitch_index_decode pid_checker u_pid_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req_valid),
  .req_stall      (req_stall),
  .rsp_valid      (rsp_valid),
  .rsp_stall      (rsp_stall),
  .pitch_q19      (pitch_q19),
  .harmonic_total (harmonic_total)
);

// ===== test/pitch_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pitch_check: scoreboard for the pitch index decoder
// Watches both channels. Every accepted index is decoded here into the
// fundamental and harmonic count it must produce. Every accepted response is
// compared against the oldest outstanding word.
// ----------------------------------------------------------------------------
module pitch_check #(
  parameter int INDEX_BITS = pid_pkg::INDEX_BITS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  input  logic                         req_stall,
  input  logic [INDEX_BITS-1:0]        pitch_index,
  input  logic                         rsp_valid,
  input  logic                         rsp_stall,
  input  logic [pid_pkg::PITCH_W-1:0]  pitch_q19,
  input  logic [pid_pkg::HARM_W-1:0]   harmonic_total,
  output int                           mismatch_count,
  output int                           open_words
);

  typedef struct packed {
    logic [pid_pkg::PITCH_W-1:0] f0;
    logic [pid_pkg::HARM_W-1:0]  harm;
  } pitch_word_t;

  // Log-pitch law, Q12.
  localparam longint LOG_STEP   = 64'sh2A52;
  localparam longint LOG_DIV    = 64'sh3C;
  localparam longint LOG_OFFSET = 64'sh44FD;
  localparam longint ONE_Q12    = 64'sh1000;

  // Horner coefficients of 2^x on one octave.
  localparam longint COEF_LEAD = 64'sh13B;
  localparam longint COEF_1    = 64'sh71B;
  localparam longint COEF_2    = 64'sh1EC0;
  localparam longint COEF_3    = 64'sh58B9;

  localparam longint F0_LOW  = 64'sh1079;
  localparam longint F0_HIGH = 64'sh6BCA;

  localparam longint HARM_SPAN   = 64'sh3B39C;
  localparam longint NYQ_SPAN    = 64'sh80000;
  localparam longint NYQ_EDGE    = 64'sh7FFFF;
  localparam longint MASK16      = 64'shFFFF;
  localparam longint UNIT16      = 64'sh10000;
  localparam longint HARM_FLOOR  = 64'sd9;
  localparam longint HARM_CEIL   = 64'sh38;

  pitch_word_t expected_words[$];
  int          errs = 0;

  function automatic longint sext16(input longint v);
    logic [15:0] lo;
    lo = v[15:0];
    return longint'(signed'(lo));
  endfunction

  // 2^x for a Q12 exponent, giving the fundamental in Q19.
  function automatic longint exp2_q19(input longint x);
    longint      arg;
    longint      octave;
    longint      t;
    longint      prod;
    logic [15:0] frac;
    logic [4:0]  sh;
    arg    = sext16(x);
    octave = -4;
    while (arg < -ONE_Q12) begin
      arg    = sext16(arg + ONE_Q12);
      octave = sext16(octave + 1);
    end
    t    = ((arg * COEF_LEAD) >>> 12) + COEF_1;
    t    = sext16(((t * arg) >>> 12) + COEF_2);
    t    = sext16(((t * arg) >>> 12) + COEF_3);
    prod = (t * arg) >>> 12;
    frac = prod[15:0] ^ 16'h8000;
    sh   = octave[4:0];
    return longint'(signed'(frac)) >>> sh;
  endfunction

  // Harmonics up to the band edge, with the Nyquist guard and clamping.
  function automatic longint band_harmonics(input longint f0);
    longint l;
    l = (HARM_SPAN / f0) & MASK16;
    if ((((2 * l + 1) & MASK16) * f0) > NYQ_EDGE) begin
      l = (((NYQ_SPAN / f0) * UNIT16 - UNIT16) >>> 17) & MASK16;
    end
    if (l >= HARM_CEIL) begin
      l = HARM_CEIL;
    end else if (l < HARM_FLOOR) begin
      l = HARM_FLOOR;
    end
    return l;
  endfunction

  function automatic pitch_word_t decode_pitch(input logic [INDEX_BITS-1:0] code);
    longint      num;
    longint      den;
    longint      f0;
    longint      harm;
    pitch_word_t w;
    num = (2 * longint'(code) + 1) * LOG_STEP;
    den = (LOG_DIV << (INDEX_BITS - 6)) * 2;
    f0  = exp2_q19(-((num / den) + LOG_OFFSET));
    if (f0 < F0_LOW) begin
      f0 = F0_LOW;
    end
    if (f0 > F0_HIGH) begin
      f0 = F0_HIGH;
    end
    harm   = band_harmonics(f0);
    w.f0   = f0[pid_pkg::PITCH_W-1:0];
    w.harm = harm[pid_pkg::HARM_W-1:0];
    return w;
  endfunction

  always @(posedge clk) begin
    pitch_word_t want;
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_words.size() == 0) begin
          $error("unexpected word: pitch_q19 %0d, harmonic_total %0d",
                 pitch_q19, harmonic_total);
          errs++;
        end else begin
          want = expected_words.pop_front();
          if (pitch_q19 !== want.f0) begin
            $error("pitch_q19 mismatch: expected %0d, actual %0d", want.f0, pitch_q19);
            errs++;
          end
          if (harmonic_total !== want.harm) begin
            $error("harmonic_total mismatch: expected %0d, actual %0d",
                   want.harm, harmonic_total);
            errs++;
          end
        end
      end
      if (req_valid && !req_stall) begin
        expected_words.push_back(decode_pitch(pitch_index));
      end
    end
    mismatch_count <= errs;
    open_words     <= expected_words.size();
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: top level for the pitch index decoder
// Feeds a directed sweep of indices, then random indices in bursts with
// random gaps, while the response side stalls on its own pattern and holds
// off once for a long stretch. The scoreboard reports the mismatch count.
// ----------------------------------------------------------------------------
module tb;

  localparam int INDEX_BITS  = pid_pkg::INDEX_BITS_DEFAULT;
  localparam int TOTAL_WORDS = 1050;
  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_AFTER  = 300;
  localparam int HOLD_CYCLES = 600;
  localparam int TAIL_CYCLES = 120;

  typedef enum {STALL_NONE, STALL_HALF, STALL_HEAVY, STALL_LIGHT} stall_mode_t;

  logic                         clk;
  logic                         rst;
  logic                         req_valid;
  logic                         req_stall;
  logic [INDEX_BITS-1:0]        pitch_index;
  logic                         rsp_valid;
  logic                         rsp_stall;
  logic [pid_pkg::PITCH_W-1:0]  pitch_q19;
  logic [pid_pkg::HARM_W-1:0]   harmonic_total;
  int                           mismatch_count;
  int                           open_words;
  int                           items_sent = 0;

  wire req_fire = req_valid && !req_stall;
  wire rsp_fire = rsp_valid && !rsp_stall;

  pitch_index_decode #(.INDEX_BITS(INDEX_BITS)) dut (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .pitch_index   (pitch_index),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .pitch_q19     (pitch_q19),
    .harmonic_total(harmonic_total)
  );

  pitch_check #(.INDEX_BITS(INDEX_BITS)) check (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .pitch_index   (pitch_index),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .pitch_q19     (pitch_q19),
    .harmonic_total(harmonic_total),
    .mismatch_count(mismatch_count),
    .open_words    (open_words)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Present one index and hold it until the decoder takes the word.
  task automatic offer(input logic [INDEX_BITS-1:0] code);
    req_valid   <= 1'b1;
    pitch_index <= code;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    items_sent++;
  endtask

  initial begin : stimulus
    int burst;
    int gap;
    logic [INDEX_BITS-1:0] sweep[$];
    rst         <= 1'b1;
    req_valid   <= 1'b0;
    pitch_index <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Both ends of the index range, the edges of each group of 16 indices, and
    // alternating bit patterns, sent back to back.
    sweep = '{7'd0, 7'd1, 7'd2, 7'd3, 7'd15, 7'd16, 7'd31, 7'd32, 7'd47, 7'd48,
              7'd63, 7'd64, 7'd79, 7'd80, 7'd95, 7'd96, 7'd111, 7'd112,
              7'd125, 7'd126, 7'd127, 7'h55, 7'h2A};
    foreach (sweep[i]) offer(sweep[i]);

    while (items_sent < TOTAL_WORDS) begin
      burst = $urandom_range(1, 24);
      for (int n = 0; n < burst && items_sent < TOTAL_WORDS; n++) begin
        offer(INDEX_BITS'($urandom_range(0, (1 << INDEX_BITS) - 1)));
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap != 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    req_valid <= 1'b0;

    @(posedge clk);
    while (open_words != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Decoded %0d pitch indices: a directed sweep plus random bursts,", items_sent);
    $display("with random output stalls and one %0d-cycle output hold.", HOLD_CYCLES);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Response side: stalls follow a mode that changes every stretch, and the
  // decoder is starved of output space once, long enough to back up its input.
  initial begin : drain
    stall_mode_t mode;
    int span;
    bit held;
    held = 1'b0;
    rsp_stall <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held && items_sent >= HOLD_AFTER) begin
        held = 1'b1;
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      mode = stall_mode_t'($urandom_range(0, 3));
      span = $urandom_range(20, 300);
      repeat (span) begin
        case (mode)
          STALL_NONE:  rsp_stall <= 1'b0;
          STALL_HALF:  rsp_stall <= ($urandom_range(0, 1) == 1);
          STALL_HEAVY: rsp_stall <= ($urandom_range(0, 7) != 0);
          default:     rsp_stall <= ($urandom_range(0, 7) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // Ends the run if neither channel moves a word for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || req_fire || rsp_fire) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("TB_ERROR");
    $finish;
  end

endmodule
